// ===== hdl/pbdt_pkg.sv =====
package pbdt_pkg;

    // Ring depth and derived widths
    localparam int BUF_DEPTH  = 64;
    localparam int RING_AW    = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
    localparam int CNT_W      = $clog2(BUF_DEPTH + 1);
    localparam int SIZE_W     = 7;
    localparam int CAP_W      = (CNT_W > SIZE_W) ? CNT_W : SIZE_W;

    // Payload widths
    localparam int ARRIVAL_W  = 32;
    localparam int PROC_W     = 16;
    localparam int TIME_W     = 33;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;
    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(1);

    typedef logic [TIME_W-1:0]  t_time;
    typedef logic [RING_AW-1:0] t_ring_addr;
    typedef logic [CNT_W-1:0]   t_count;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_CALC,
        S_PUSH
    } t_state;

endpackage

// ===== hdl/pbdt_if.sv =====
interface pbdt_in_if;
    import pbdt_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [ARRIVAL_W-1:0] arrival_time;
    logic [PROC_W-1:0]    process_time;

    modport source (output valid, output arrival_time, output process_time, input ready);
    modport sink   (input valid, input arrival_time, input process_time, output ready);
endinterface

interface pbdt_out_if;
    import pbdt_pkg::*;

    logic              valid;
    logic              ready;
    logic [TIME_W-1:0] start_time;
    logic              dropped;

    modport source (output valid, output start_time, output dropped, input ready);
    modport sink   (input valid, input start_time, input dropped, output ready);
endinterface

// ===== hdl/packet_buffer_drop_tail_sim_top.sv =====
// Drop-tail packet buffer model. Each input transfer is one packet (arrival
// time, processing time); each output transfer gives its start time and a
// dropped flag, one result per packet, in order. Finish times of held packets
// live in a 64-entry ring memory. For each packet one compare unit walks the
// ring head one entry per cycle, retiring held packets that have finished,
// then picks the start time or drops a full-buffer packet, then one adder
// forms the saturated finish time. The input is not ready while a packet is
// in work or while its result waits for the sink. buffer_size is written
// through i_cfg_we/i_cfg_wdata while the block is idle; the user must keep
// to this, as the block does not enforce it. Values above the ring depth act
// as the ring depth, and zero drops every packet.
module packet_buffer_drop_tail_sim_top
    import pbdt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [SIZE_W-1:0] i_cfg_wdata,
    pbdt_in_if.sink           i_in,
    pbdt_out_if.source        o_out
);

    t_state r_state, n_state;

    logic [SIZE_W-1:0]    r_buffer_size;
    t_ring_addr           r_head, n_head;
    t_count               r_held, n_held;
    t_time                r_last_finish, n_last_finish;
    logic [ARRIVAL_W-1:0] r_arrival;
    logic [PROC_W-1:0]    r_proc;
    t_time                r_start, n_start;

    logic                 r_out_valid, n_out_valid;
    t_time                r_out_start, n_out_start;
    logic                 r_out_dropped, n_out_dropped;

    // Ring memory
    t_time                r_ring [BUF_DEPTH];
    t_time                r_rdata;
    t_ring_addr           rd_addr;
    t_ring_addr           wr_addr;
    logic                 wr_en;

    logic                 accept;
    logic                 retire;
    t_time                cmp_lhs;
    logic                 cmp_le;
    logic [CAP_W-1:0]     cap;
    logic                 full;
    t_ring_addr           head_inc;
    logic [RING_AW:0]     slot_sum;
    logic [TIME_W:0]      fin_sum;
    t_time                finish;

    assign accept = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE) && (!r_out_valid || o_out.ready);

    assign o_out.valid      = r_out_valid;
    assign o_out.start_time = r_out_start;
    assign o_out.dropped    = r_out_dropped;

    // Shared comparator: ring head against arrival, then last finish against arrival
    assign cmp_lhs = (r_state == S_CHECK) ? r_rdata : r_last_finish;
    assign cmp_le  = cmp_lhs <= {1'b0, r_arrival};

    assign retire   = (r_state == S_CHECK) && (r_held != '0) && cmp_le;
    assign head_inc = (r_head == RING_AW'(BUF_DEPTH - 1)) ? '0 : r_head + 1'b1;

    // Effective capacity
    always_comb begin
        if (CAP_W'(r_buffer_size) > CAP_W'(BUF_DEPTH)) begin
            cap = CAP_W'(BUF_DEPTH);
        end else begin
            cap = CAP_W'(r_buffer_size);
        end
    end
    assign full = CAP_W'(r_held) >= cap;

    // Tail slot: head + held, wrapped once
    assign slot_sum = {1'b0, r_head} + (RING_AW + 1)'(r_held);
    always_comb begin
        if (slot_sum >= (RING_AW + 1)'(BUF_DEPTH)) begin
            wr_addr = RING_AW'(slot_sum - (RING_AW + 1)'(BUF_DEPTH));
        end else begin
            wr_addr = slot_sum[RING_AW-1:0];
        end
    end

    // Saturated finish time
    assign fin_sum = {1'b0, r_start} + (TIME_W + 1)'(r_proc);
    assign finish  = fin_sum[TIME_W] ? TIME_MAX : fin_sum[TIME_W-1:0];

    // Read the head entry ahead; follow the next entry while retiring
    assign rd_addr = retire ? head_inc : r_head;
    assign wr_en   = (r_state == S_PUSH);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_ring[wr_addr] <= finish;
        end
        r_rdata <= r_ring[rd_addr];
    end

    // Sequencer
    always_comb begin
        n_state       = r_state;
        n_head        = r_head;
        n_held        = r_held;
        n_last_finish = r_last_finish;
        n_start       = r_start;
        n_out_valid   = r_out_valid;
        n_out_start   = r_out_start;
        n_out_dropped = r_out_dropped;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (retire) begin
                    n_head = head_inc;
                    n_held = r_held - 1'b1;
                end else begin
                    n_state = S_CALC;
                end
            end
            S_CALC: begin
                if (full) begin
                    n_out_valid   = 1'b1;
                    n_out_start   = '0;
                    n_out_dropped = 1'b1;
                    n_state       = S_IDLE;
                end else begin
                    n_start = cmp_le ? {1'b0, r_arrival} : r_last_finish;
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                n_held        = r_held + 1'b1;
                n_last_finish = finish;
                n_out_valid   = 1'b1;
                n_out_start   = r_start;
                n_out_dropped = 1'b0;
                n_state       = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_head        <= '0;
            r_held        <= '0;
            r_last_finish <= '0;
            r_buffer_size <= SIZE_RESET;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_head        <= n_head;
            r_held        <= n_held;
            r_last_finish <= n_last_finish;
            r_out_valid   <= n_out_valid;
            if (i_cfg_we) begin
                r_buffer_size <= i_cfg_wdata;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_arrival <= i_in.arrival_time;
            r_proc    <= i_in.process_time;
        end
        r_start       <= n_start;
        r_out_start   <= n_out_start;
        r_out_dropped <= n_out_dropped;
    end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import pbdt_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int PHASE_ITEMS  = 128;
    localparam int PHASE_COUNT  = 9;
    localparam int DRAIN_CYCLES = 80;

    typedef enum logic { ROW_PKT, ROW_CFG } row_kind_e;

    typedef struct packed {
        t_time start_time;
        logic  dropped;
    } pkt_result_t;

    typedef struct packed {
        row_kind_e            kind;
        logic [ARRIVAL_W-1:0] arrival;
        logic [PROC_W-1:0]    proc;
        logic [SIZE_W-1:0]    size;
        logic                 typed;
        t_time                exp_start;
        logic                 exp_drop;
    } dir_row_t;

    // Directed table: typed rows carry an expected result, others use the predictor
    localparam int DIR_ROWS = 22;
    localparam dir_row_t DIR_PLAN [DIR_ROWS] = '{
        // reset size 1: empty buffer, zero and max processing times
        '{ROW_PKT, 32'd0,      16'd0,     7'd0,   1'b1, 33'd0,     1'b0},
        '{ROW_PKT, 32'd0,      16'hFFFF,  7'd0,   1'b1, 33'd0,     1'b0},
        // buffer full, nothing retires
        '{ROW_PKT, 32'd10,     16'd5,     7'd0,   1'b1, 33'd0,     1'b1},
        // arrival equal to finish retires the entry
        '{ROW_PKT, 32'd65535,  16'd1,     7'd0,   1'b1, 33'd65535, 1'b0},
        // zero size drops everything
        '{ROW_CFG, 32'd0,      16'd0,     7'd0,   1'b0, 33'd0,     1'b0},
        '{ROW_PKT, 32'd70000,  16'd3,     7'd0,   1'b1, 33'd0,     1'b1},
        // fill a three-deep buffer
        '{ROW_CFG, 32'd0,      16'd0,     7'd3,   1'b0, 33'd0,     1'b0},
        '{ROW_PKT, 32'd100000, 16'd1000,  7'd0,   1'b0, 33'd0,     1'b0},
        '{ROW_PKT, 32'd100000, 16'd1000,  7'd0,   1'b0, 33'd0,     1'b0},
        '{ROW_PKT, 32'd100000, 16'd1000,  7'd0,   1'b0, 33'd0,     1'b0},
        '{ROW_PKT, 32'd100000, 16'd1000,  7'd0,   1'b1, 33'd0,     1'b1},
        // oversize value saturates to the ring depth
        '{ROW_CFG, 32'd0,      16'd0,     7'd127, 1'b0, 33'd0,     1'b0},
        '{ROW_PKT, 32'd100000, 16'd7,     7'd0,   1'b0, 33'd0,     1'b0},
        // shrink while four packets are held
        '{ROW_CFG, 32'd0,      16'd0,     7'd1,   1'b0, 33'd0,     1'b0},
        '{ROW_PKT, 32'd101500, 16'd2,     7'd0,   1'b1, 33'd0,     1'b1},
        '{ROW_PKT, 32'd103007, 16'd2,     7'd0,   1'b0, 33'd0,     1'b0},
        // arrival going backwards
        '{ROW_PKT, 32'd50,     16'd4,     7'd0,   1'b1, 33'd0,     1'b1},
        '{ROW_CFG, 32'd0,      16'd0,     7'd2,   1'b0, 33'd0,     1'b0},
        '{ROW_PKT, 32'd50,     16'd4,     7'd0,   1'b0, 33'd0,     1'b0},
        '{ROW_CFG, 32'd0,      16'd0,     7'd64,  1'b0, 33'd0,     1'b0},
        '{ROW_PKT, 32'd103020, 16'hFFFF,  7'd0,   1'b0, 33'd0,     1'b0},
        '{ROW_CFG, 32'd0,      16'd0,     7'd65,  1'b0, 33'd0,     1'b0}
    };

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [SIZE_W-1:0] i_cfg_wdata;

    pbdt_in_if  pkt_in ();
    pbdt_out_if res_out ();

    packet_buffer_drop_tail_sim_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (pkt_in),
        .o_out       (res_out)
    );

    always #5 i_clk = ~i_clk;

    // Shadow buffer state
    t_time             fin_ring [BUF_DEPTH];
    t_ring_addr        ring_hd     = '0;
    int                held_pkts   = 0;
    t_time             last_fin    = '0;
    logic [SIZE_W-1:0] buf_size    = SIZE_RESET;

    pkt_result_t       pending_results [$];
    int                mismatch_count = 0;
    int                cyc_count      = 0;
    bit                src_calm       = 1'b0;
    bit                snk_calm       = 1'b0;

    function automatic int draw_wait(input bit calm);
        return calm ? 0 : $urandom_range(0, 8);
    endfunction

    // Retire finished packets, then drop or schedule this one
    function automatic pkt_result_t schedule_packet(input logic [ARRIVAL_W-1:0] arr,
                                                    input logic [PROC_W-1:0] proc);
        int          cap;
        t_time       begin_at;
        logic [TIME_W:0] sum;
        pkt_result_t res;
        cap = (int'(buf_size) > BUF_DEPTH) ? BUF_DEPTH : int'(buf_size);
        while (held_pkts > 0 && fin_ring[ring_hd] <= t_time'(arr)) begin
            ring_hd   = ring_hd + 1'b1;
            held_pkts = held_pkts - 1;
        end
        if (held_pkts >= cap) begin
            res.start_time = '0;
            res.dropped    = 1'b1;
            return res;
        end
        begin_at = (t_time'(arr) > last_fin) ? t_time'(arr) : last_fin;
        sum      = {1'b0, begin_at} + proc;
        last_fin = (sum > {1'b0, TIME_MAX}) ? TIME_MAX : sum[TIME_W-1:0];
        fin_ring[t_ring_addr'(ring_hd + t_ring_addr'(held_pkts))] = last_fin;
        held_pkts      = held_pkts + 1;
        res.start_time = begin_at;
        res.dropped    = 1'b0;
        return res;
    endfunction

    // Present one packet, hold it until the transfer, log its expected result
    task automatic send_packet(input logic [ARRIVAL_W-1:0] arr, input logic [PROC_W-1:0] proc,
                               input logic typed, input t_time ex_start, input logic ex_drop);
        int          gap;
        pkt_result_t res;
        gap = draw_wait(src_calm);
        if (gap > 0) begin
            pkt_in.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        pkt_in.arrival_time = arr;
        pkt_in.process_time = proc;
        pkt_in.valid        = 1'b1;
        do @(posedge i_clk); while (!pkt_in.ready);
        res = schedule_packet(arr, proc);
        if (typed) begin
            res.start_time = ex_start;
            res.dropped    = ex_drop;
        end
        pending_results.push_back(res);
        @(negedge i_clk);
    endtask

    // Register write once the block has gone idle
    task automatic write_buffer_size(input logic [SIZE_W-1:0] sz);
        pkt_in.valid = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = sz;
        buf_size    = sz;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    // Result sink with random stalls
    initial begin
        int stall;
        res_out.ready = 1'b0;
        forever begin
            stall = draw_wait(snk_calm);
            if (stall > 0) begin
                res_out.ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            res_out.ready = 1'b1;
            do @(posedge i_clk); while (!(res_out.valid && res_out.ready));
            @(negedge i_clk);
        end
    end

    // Compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin
        pkt_result_t exp_res;
        if (i_rst_n && res_out.valid && res_out.ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: start_time %0d dropped %0b",
                       res_out.start_time, res_out.dropped);
                mismatch_count++;
            end else begin
                exp_res = pending_results.pop_front();
                if (res_out.start_time !== exp_res.start_time) begin
                    $error("start_time: expected %0d, got %0d",
                           exp_res.start_time, res_out.start_time);
                    mismatch_count++;
                end
                if (res_out.dropped !== exp_res.dropped) begin
                    $error("dropped: expected %0b, got %0b",
                           exp_res.dropped, res_out.dropped);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cyc_count <= cyc_count + 1;
        if (cyc_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        logic [SIZE_W-1:0]    sizes [PHASE_COUNT];
        logic [ARRIVAL_W-1:0] arr_now;
        logic [ARRIVAL_W-1:0] arr;
        logic [ARRIVAL_W:0]   nxt;
        logic [ARRIVAL_W-1:0] delta;
        logic [PROC_W-1:0]    proc;
        int                   pick;
        dir_row_t             row;

        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_wdata         = '0;
        pkt_in.valid        = 1'b0;
        pkt_in.arrival_time = '0;
        pkt_in.process_time = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed table
        for (int r = 0; r < DIR_ROWS; r++) begin
            row = DIR_PLAN[r];
            if (row.kind == ROW_CFG)
                write_buffer_size(row.size);
            else
                send_packet(row.arrival, row.proc, row.typed, row.exp_start, row.exp_drop);
        end

        // Random phases, one buffer size each; arrivals climb phase by phase
        sizes = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd0, 7'd65, 7'd0, 7'd4, 7'd64};
        sizes[4] = SIZE_W'($urandom_range(2, 8));
        sizes[6] = SIZE_W'($urandom_range(1, 64));
        arr_now  = 32'd103020;
        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            write_buffer_size(sizes[ph]);
            src_calm = ($urandom_range(0, 3) == 0);
            snk_calm = ($urandom_range(0, 3) == 0);
            if (ph == PHASE_COUNT - 1)
                arr = 32'hFFFF_FFFF - $urandom_range(0, 32'h0020_0000);
            else
                arr = ph * 32'h1C00_0000 + $urandom_range(0, 32'h0FFF_FFFF);
            if (arr > arr_now)
                arr_now = arr;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(0, 9);
                if (pick < 5)
                    proc = PROC_W'($urandom_range(0, 200));
                else if (pick < 8)
                    proc = PROC_W'($urandom_range(0, 65535));
                else if (pick == 8)
                    proc = '0;
                else
                    proc = '1;
                pick = $urandom_range(0, 19);
                if (pick < 8)
                    delta = $urandom_range(0, 150);
                else if (pick < 14)
                    delta = $urandom_range(0, 3000);
                else if (pick < 17)
                    delta = '0;
                else if (pick < 19)
                    delta = $urandom_range(0, 70000);
                else
                    delta = $urandom_range(0, 1 << 22);
                // occasional step backwards in time, otherwise advance and clamp
                if ($urandom_range(0, 19) == 0) begin
                    delta = $urandom_range(0, 5000);
                    arr   = (arr_now > delta) ? arr_now - delta : '0;
                end else begin
                    nxt     = {1'b0, arr_now} + delta;
                    arr_now = nxt[ARRIVAL_W] ? '1 : nxt[ARRIVAL_W-1:0];
                    arr     = arr_now;
                end
                send_packet(arr, proc, 1'b0, '0, 1'b0);
            end
        end

        // Drain and finish
        pkt_in.valid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
